/* rtl/core/pfra_pkg.sv */
package pfra_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int ANGLE_DROP = 16 - ANGLE_BITS;
    localparam logic [15:0] ANGLE_MASK = 16'hFFFF << ANGLE_DROP;

    localparam logic [15:0] LOW_D_Q16 = 16'd19661;
    localparam logic [16:0] MAX_FORCE_MAG = 17'd17254;
    localparam logic [16:0] FORCE_CLAMP = 17'd32768;
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
    localparam logic [15:0] MAX_RANGE_RESET = 16'd1600;
    localparam logic [15:0] CENTRE_RESET = 16'd16384;

    localparam int CORDIC_STEPS = 16;
    localparam int XY_W = 36;
    localparam int Z_W = 22;
    localparam int NUM_W = 62;
    localparam int DEN_W = 48;

    localparam logic [1:0] MODE_PROX = 2'd0;
    localparam logic [1:0] MODE_PKT = 2'd1;

    localparam logic REG_MAX_RANGE = 1'b0;
    localparam logic REG_CENTRE = 1'b1;

    typedef struct packed {
        logic        busy;
        logic        sat;
        logic [15:0] quot;
    } div_status_t;

    function automatic logic signed [Z_W-1:0] atan_val(input logic [3:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            4'd0:    v = 22'sd131072;
            4'd1:    v = 22'sd77376;
            4'd2:    v = 22'sd40884;
            4'd3:    v = 22'sd20753;
            4'd4:    v = 22'sd10417;
            4'd5:    v = 22'sd5213;
            4'd6:    v = 22'sd2607;
            4'd7:    v = 22'sd1304;
            4'd8:    v = 22'sd652;
            4'd9:    v = 22'sd326;
            4'd10:   v = 22'sd163;
            4'd11:   v = 22'sd81;
            4'd12:   v = 22'sd41;
            4'd13:   v = 22'sd20;
            4'd14:   v = 22'sd10;
            default: v = 22'sd5;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [XY_W-1:0] b);
        logic signed [XY_W:0] s;
        logic signed [31:0] r;
        s = $signed({{(XY_W-31){a[31]}}, a}) + $signed({b[XY_W-1], b});
        if (s > $signed({{(XY_W-31){1'b0}}, 32'h7FFFFFFF}))
            r = 32'sh7FFFFFFF;
        else if (s < $signed({{(XY_W-31){1'b1}}, 32'h80000000}))
            r = 32'sh80000000;
        else
            r = s[31:0];
        return r;
    endfunction

endpackage

/* rtl/core/pfra_mul.sv */
module pfra_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [15:0] b,
    output logic [47:0] p
);
    logic [47:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= {16'b0, a} * {32'b0, b};
    end

    assign p = p_reg;
endmodule

/* rtl/core/pfra_div.sv */
module pfra_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [pfra_pkg::NUM_W-1:0] num,
    input  logic [pfra_pkg::DEN_W-1:0] den,
    output pfra_pkg::div_status_t    status
);
    import pfra_pkg::*;

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [15:0]      quot_reg, quot_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             sat_reg, sat_next;
    logic [4:0]       cnt_m1;
    logic [63:0]      shifted;
    logic             fits;

    assign cnt_m1  = cnt_reg - 5'd1;
    assign shifted = {16'b0, den_reg} << cnt_m1[3:0];
    assign fits    = {2'b0, rem_reg} >= shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            quot_next = 16'd0;
            sat_next  = {4'b0, num} >= {2'b0, den, 16'b0};
            cnt_next  = sat_next ? 5'd0 : 5'd16;
        end
        else if (cnt_reg != 5'd0)
        begin
            quot_next = {quot_reg[14:0], fits};
            if (fits)
                rem_next = rem_reg - shifted[NUM_W-1:0];
            cnt_next = cnt_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 5'd0;
            sat_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sat_reg <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign status.busy = cnt_reg != 5'd0;
    assign status.sat  = sat_reg;
    assign status.quot = quot_reg;

`ifndef NO_ASSERTIONS
    a_sat_no_iter: assert property (@(posedge clk) disable iff (!rst_n)
        (start && {4'b0, num} >= {2'b0, den, 16'b0}) |=> !status.busy)
        else $error("saturated divide still iterating");
    a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
        (!start && cnt_reg != 5'd0) |=> cnt_reg == $past(cnt_reg) - 5'd1)
        else $error("divide counter skipped");
    a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (cnt_reg == 5'd16 || cnt_reg == 5'd0))
        else $error("divide start count wrong");
`endif
endmodule

/* rtl/core/pfra_cordic.sv */
module pfra_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic signed [pfra_pkg::XY_W-1:0]  x0,
    input  logic signed [pfra_pkg::Z_W-1:0]   z0,
    output logic                              busy,
    output logic signed [pfra_pkg::XY_W-1:0]  x,
    output logic signed [pfra_pkg::XY_W-1:0]  y
);
    import pfra_pkg::*;

    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [4:0]             cnt_reg, cnt_next;

    assign xs = x_reg >>> cnt_reg[3:0];
    assign ys = y_reg >>> cnt_reg[3:0];

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            x_next   = x0;
            y_next   = '0;
            z_next   = z0;
            cnt_next = 5'd0;
        end
        else if (!cnt_reg[4])
        begin
            if (!z_reg[Z_W-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_val(cnt_reg[3:0]);
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_val(cnt_reg[3:0]);
            end
            cnt_next = cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 5'd16;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy = !cnt_reg[4];
    assign x    = x_reg;
    assign y    = y_reg;
endmodule

/* rtl/core/potential_field_repulsion_accumulator.sv */
// a packet in range runs S_DIST first; an item with no reading goes straight to S_FIN; others
// run S_SQ, S_CUBE, S_CSQ, S_PREP, S_FDIV (the last four skipped when the force is
// clamped or zero), S_SCALE, S_XLD, S_ROT, S_FIN (16-step divides, the force divide none
// if saturated, 16 cordic steps, shared multiplier); s_tready is high only while idle
// a result waits in the output register while the next item is accepted
// reset (rst_n, async low) clears sums, registers to their defaults and the sequencer
module potential_field_repulsion_accumulator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,  // magnitude, bearing
    input  logic [2:0]   s_tuser,  // mode, first
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata   // total_x, total_y, prox_x, prox_y, pkt_x, pkt_y
);
    import pfra_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DIST  = 11'b00000000010,
        S_SQ    = 11'b00000000100,
        S_CUBE  = 11'b00000001000,
        S_CSQ   = 11'b00000010000,
        S_PREP  = 11'b00000100000,
        S_FDIV  = 11'b00001000000,
        S_SCALE = 11'b00010000000,
        S_XLD   = 11'b00100000000,
        S_ROT   = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] max_range_reg, centre_reg;
    logic signed [31:0] prox_x_reg, prox_x_next, prox_y_reg, prox_y_next;
    logic signed [31:0] pkt_x_reg, pkt_x_next, pkt_y_reg, pkt_y_next;
    logic [15:0] d_reg, d_next, bear_reg, bear_next;
    logic        pkt_reg, pkt_next, last_reg, last_next, use_reg, use_next;
    logic [31:0] dd_reg, dd_next;
    logic [47:0] den_reg, den_next;
    logic [16:0] fmag_reg, fmag_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [191:0] m_tdata_reg, m_tdata_next;

    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [47:0] mul_p;
    logic        div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    div_status_t div_st;
    logic        cor_load, cor_busy;
    logic signed [XY_W-1:0] cor_x0, cor_x, cor_y, fx, fy;
    logic signed [Z_W-1:0]  cor_z0;
    logic [15:0] angle;
    logic [35:0] diff;
    logic [15:0] qv;
    logic        wr, accept;

    pfra_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
    pfra_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
                    .den(div_den), .status(div_st));
    pfra_cordic u_cordic (.clk(clk), .rst_n(rst_n), .load(cor_load), .x0(cor_x0),
                          .z0(cor_z0), .busy(cor_busy), .x(cor_x), .y(cor_y));

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_CENTRE) ? {16'b0, centre_reg} : {16'b0, max_range_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_reg <= MAX_RANGE_RESET;
            centre_reg    <= CENTRE_RESET;
        end
        else if (wr)
        begin
            if (paddr[2] == REG_MAX_RANGE)
                max_range_reg <= pwdata[15:0];
            else
                centre_reg <= pwdata[15:0];
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign angle    = bear_reg & ANGLE_MASK;
    assign diff     = {centre_reg_sq_hi(mul_p), 4'b0} - {4'b0, dd_reg};
    assign qv       = div_st.quot;
    assign fx       = cor_x >>> 8;
    assign fy       = cor_y >>> 8;

    function automatic logic [31:0] centre_reg_sq_hi(input logic [47:0] p);
        return p[31:0];
    endfunction

    always_comb
    begin
        state_next    = state_reg;
        prox_x_next   = prox_x_reg;
        prox_y_next   = prox_y_reg;
        pkt_x_next    = pkt_x_reg;
        pkt_y_next    = pkt_y_reg;
        d_next        = d_reg;
        bear_next     = bear_reg;
        pkt_next      = pkt_reg;
        last_next     = last_reg;
        use_next      = use_reg;
        dd_next       = dd_reg;
        den_next      = den_reg;
        fmag_next     = fmag_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mul_a         = {16'b0, d_reg};
        mul_b         = d_reg;
        div_start     = 1'b0;
        div_num       = {16'b0, s_tdata[15:0], 30'b0} >> 14;
        div_den       = {32'b0, max_range_reg};
        cor_load      = 1'b0;
        cor_x0        = -$signed(mul_p[XY_W-1:0]);
        cor_z0        = $signed({2'b0, angle, 4'b0});
        case (angle[15:14])
            2'b01, 2'b10:
            begin
                cor_x0 = $signed(mul_p[XY_W-1:0]);
                cor_z0 = $signed({2'b0, angle, 4'b0}) - 22'sd524288;
            end
            2'b11:   cor_z0 = $signed({2'b0, angle, 4'b0}) - 22'sd1048576;
            default: cor_z0 = $signed({2'b0, angle, 4'b0});
        endcase
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    bear_next = s_tdata[31:16];
                    last_next = s_tlast;
                    if (s_tuser[2])
                    begin
                        prox_x_next = '0;
                        prox_y_next = '0;
                        pkt_x_next  = '0;
                        pkt_y_next  = '0;
                    end
                    if (s_tuser[1:0] == MODE_PROX && s_tdata[15:0] != 16'd0)
                    begin
                        d_next     = 16'd0 - s_tdata[15:0];
                        pkt_next   = 1'b0;
                        use_next   = 1'b1;
                        state_next = S_SQ;
                    end
                    else if (s_tuser[1:0] == MODE_PKT && s_tdata[15:0] < max_range_reg)
                    begin
                        pkt_next   = 1'b1;
                        use_next   = 1'b1;
                        div_start  = 1'b1;
                        state_next = S_DIST;
                    end
                    else
                    begin
                        use_next   = 1'b0;
                        state_next = S_FIN;
                    end
                end
            end
            S_DIST:
            begin
                if (!div_st.busy)
                begin
                    d_next     = qv;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (d_reg < LOW_D_Q16)
                begin
                    fmag_next  = MAX_FORCE_MAG;
                    state_next = S_SCALE;
                end
                else if ({2'b0, d_reg} > {centre_reg, 2'b0})
                begin
                    fmag_next  = 17'd0;
                    state_next = S_SCALE;
                end
                else
                    state_next = S_CUBE;
            end
            S_CUBE:
            begin
                dd_next    = mul_p[31:0];
                mul_a      = mul_p[31:0];
                state_next = S_CSQ;
            end
            S_CSQ:
            begin
                den_next   = mul_p;
                mul_a      = {16'b0, centre_reg};
                mul_b      = centre_reg;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                div_start  = 1'b1;
                div_num    = {1'b0, diff[35:0], 25'b0};
                div_den    = den_reg;
                state_next = S_FDIV;
            end
            S_FDIV:
            begin
                if (!div_st.busy)
                begin
                    if (div_st.sat || {1'b0, qv} > FORCE_CLAMP)
                        fmag_next = FORCE_CLAMP;
                    else
                        fmag_next = {1'b0, qv};
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                mul_a      = {15'b0, fmag_reg};
                mul_b      = INV_GAIN_Q16;
                state_next = S_XLD;
            end
            S_XLD:
            begin
                cor_load   = 1'b1;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (!cor_busy)
                begin
                    if (pkt_reg)
                    begin
                        pkt_x_next = sat_add(pkt_x_reg, fx);
                        pkt_y_next = sat_add(pkt_y_reg, fy);
                    end
                    else
                    begin
                        prox_x_next = sat_add(prox_x_reg, fx);
                        prox_y_next = sat_add(prox_y_reg, fy);
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {pkt_y_reg, pkt_x_reg, prox_y_reg, prox_x_reg,
                                     sat_add(prox_y_reg, XY_W'(pkt_y_reg)),
                                     sat_add(prox_x_reg, XY_W'(pkt_x_reg))};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            prox_x_reg   <= '0;
            prox_y_reg   <= '0;
            pkt_x_reg    <= '0;
            pkt_y_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            last_reg     <= 1'b0;
            pkt_reg      <= 1'b0;
            use_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prox_x_reg   <= prox_x_next;
            prox_y_reg   <= prox_y_next;
            pkt_x_reg    <= pkt_x_next;
            pkt_y_reg    <= pkt_y_next;
            m_tvalid_reg <= m_tvalid_next;
            last_reg     <= last_next;
            pkt_reg      <= pkt_next;
            use_reg      <= use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        bear_reg    <= bear_next;
        dd_reg      <= dd_next;
        den_reg     <= den_next;
        fmag_reg    <= fmag_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_st.busy)
        else $error("divider busy while idle");
    a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser[2]) |=> (prox_x_reg == 0 && prox_y_reg == 0 &&
                                    pkt_x_reg == 0 && pkt_y_reg == 0))
        else $error("sums not cleared");
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg == S_FIN) && $past(last_reg)))
        else $error("result without last word");
    a_skip_no_rot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROT) |-> use_reg)
        else $error("rotation for skipped word");
`endif
endmodule
